[rtl/core/kct_pkg.sv]
// ----------------------------------------------------------------------------
// kct_pkg
// Shared types and constants of the keyed count table: request and response
// payloads, command and status codes, and the scan token passed cell to cell.
// ----------------------------------------------------------------------------
`default_nettype none

package kct_pkg;

	localparam int ENTRIES_DEF    = 32;
	localparam int KEY_BITS_DEF   = 16;
	localparam int COUNT_BITS_DEF = 31;

	localparam int KEY_W    = 16;
	localparam int AMOUNT_W = 32;
	localparam int COUNT_W  = 31;

	typedef enum logic [1:0] {
		CMD_ADD    = 2'd0,
		CMD_SET    = 2'd1,
		CMD_REMOVE = 2'd2,
		CMD_QUERY  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_DONE     = 2'd0,
		ST_INVALID  = 2'd1,
		ST_NOEFFECT = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	typedef struct packed {
		cmd_t                       command;
		logic [KEY_W-1:0]           key;
		logic signed [AMOUNT_W-1:0] amount;
		logic                       keep_zero;
	} req_t;

	typedef struct packed {
		status_t            status;
		logic [COUNT_W-1:0] count;
		logic               present;
	} rsp_t;

	typedef struct packed {
		logic valid;
		logic hit;
		logic free;
	} tok_t;

	typedef struct packed {
		logic upd;
		logic clr;
		logic ins;
	} cell_op_t;

endpackage

`default_nettype wire

[rtl/core/keyed_count_table_unit.sv]
// ----------------------------------------------------------------------------
// keyed_count_table_unit
// Table of key/count entries with add, set, remove and query requests.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. A scan token walks
// the row of ENTRIES cells, one cell per cycle, collecting the matching
// entry and the lowest free entry; the table is then updated and the
// response registered from the token that leaves the last cell. done then
// rises and is high for one cycle. busy is already low in that cycle, so
// the next request may be accepted at the edge that ends it. busy stays
// high while a request is scanned, so no new request is taken before its
// response. The receiver cannot stall: the response must be captured
// while done is high. The table is empty right after reset.
`default_nettype none

module keyed_count_table_unit import kct_pkg::*; #(
	parameter int ENTRIES    = ENTRIES_DEF,
	parameter int KEY_BITS   = KEY_BITS_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  wire  clk,
	input  wire  arst_n,
	input  wire  start,
	output logic busy,
	input  req_t req,
	output logic done,
	output rsp_t rsp
);

	localparam int IDX_W   = $clog2(ENTRIES);
	localparam int KEY_USE = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
	localparam logic [COUNT_BITS-1:0] CMAX = '1;

	typedef enum logic {S_IDLE, S_SCAN} state_t;

	state_t                state_q;
	req_t                  req_q;
	tok_t                  tok0_q;
	logic                  done_q;
	rsp_t                  rsp_q;

	tok_t                  tok_c  [0:ENTRIES];
	logic [COUNT_BITS-1:0] cnt_c  [0:ENTRIES];
	logic [IDX_W-1:0]      fidx_c [0:ENTRIES];

	logic [KEY_USE-1:0]    key_m;
	logic [AMOUNT_W-1:0]   raw;
	logic                  pos;
	logic                  big;
	logic                  want;
	logic                  fire;
	logic                  hit;
	logic [COUNT_BITS-1:0] hc;
	logic [COUNT_BITS-1:0] val;
	logic [COUNT_BITS:0]   sum;
	logic [COUNT_BITS-1:0] sat;
	logic [COUNT_BITS-1:0] diff;
	logic                  le;
	cell_op_t              op_d;
	cell_op_t              op;
	logic [COUNT_BITS-1:0] wr_count;
	status_t               st_d;
	logic [COUNT_BITS-1:0] cnt_d;
	logic                  pres_d;

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

	assign key_m = req_q.key[KEY_USE-1:0];
	assign raw   = req_q.amount;
	assign hit   = tok_c[ENTRIES].hit;
	assign hc    = cnt_c[ENTRIES];
	assign fire  = (state_q == S_SCAN) && tok_c[ENTRIES].valid;

	assign pos  = !raw[AMOUNT_W-1] && (raw != '0);
	assign big  = |raw[AMOUNT_W-1:COUNT_BITS];
	assign val  = pos ? (big ? CMAX : raw[COUNT_BITS-1:0]) : '0;
	assign sum  = {1'b0, hc} + {1'b0, val};
	assign sat  = sum[COUNT_BITS] ? CMAX : sum[COUNT_BITS-1:0];
	assign le   = (AMOUNT_W'(hc) <= raw);
	assign diff = hc - raw[COUNT_BITS-1:0];
	assign op   = fire ? op_d : '0;

	// request decision
	always_comb begin
		op_d     = '0;
		wr_count = val;
		st_d     = ST_DONE;
		cnt_d    = hit ? hc : '0;
		pres_d   = hit;
		want     = 1'b0;
		if (key_m == '0) begin
			st_d   = ST_INVALID;
			cnt_d  = '0;
			pres_d = 1'b0;
		end else begin
			unique case (req_q.command)
				CMD_ADD, CMD_SET: begin
					if (req_q.command == CMD_ADD) begin
						want = pos || ((raw == '0) && req_q.keep_zero);
					end else begin
						want = pos || req_q.keep_zero;
					end
					if (hit) begin
						if (req_q.command == CMD_ADD) begin
							if (pos) begin
								op_d.upd = 1'b1;
								wr_count = sat;
								cnt_d    = sat;
							end else begin
								st_d = ST_NOEFFECT;
							end
						end else if (want) begin
							op_d.upd = 1'b1;
							cnt_d    = val;
						end else begin
							op_d.clr = 1'b1;
							cnt_d    = '0;
							pres_d   = 1'b0;
						end
					end else if (want) begin
						if (tok_c[ENTRIES].free) begin
							op_d.ins = 1'b1;
							cnt_d    = val;
							pres_d   = 1'b1;
						end else begin
							st_d = ST_FULL;
						end
					end else begin
						st_d = ST_NOEFFECT;
					end
				end
				CMD_REMOVE: begin
					if (!pos || !hit) begin
						st_d = ST_NOEFFECT;
					end else if (le) begin
						cnt_d = '0;
						if (req_q.keep_zero) begin
							op_d.upd = 1'b1;
							wr_count = '0;
						end else begin
							op_d.clr = 1'b1;
							pres_d   = 1'b0;
						end
					end else begin
						op_d.upd = 1'b1;
						wr_count = diff;
						cnt_d    = diff;
					end
				end
				CMD_QUERY: begin
					st_d = ST_DONE;
				end
				default: begin
					st_d = ST_DONE;
				end
			endcase
		end
	end

	// control and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			tok0_q  <= '0;
			done_q  <= 1'b0;
			req_q   <= '0;
			rsp_q   <= '0;
		end else begin
			tok0_q.valid <= (state_q == S_IDLE) && start;
			done_q       <= fire;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						req_q   <= req;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (fire) begin
						rsp_q.status  <= st_d;
						rsp_q.count   <= COUNT_W'(cnt_d);
						rsp_q.present <= pres_d;
						state_q       <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// cell row
	assign tok_c[0]  = tok0_q;
	assign cnt_c[0]  = '0;
	assign fidx_c[0] = '0;

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		kct_cell #(
			.IDX        (i),
			.IDX_W      (IDX_W),
			.KEY_USE    (KEY_USE),
			.COUNT_BITS (COUNT_BITS)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.key      (key_m),
			.op       (op),
			.ins_idx  (fidx_c[ENTRIES]),
			.wr_count (wr_count),
			.tok_in   (tok_c[i]),
			.cnt_in   (cnt_c[i]),
			.fidx_in  (fidx_c[i]),
			.tok_out  (tok_c[i+1]),
			.cnt_out  (cnt_c[i+1]),
			.fidx_out (fidx_c[i+1])
		);
	end

	// checks
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("response while busy");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##(ENTRIES + 2) done)
		else $error("response latency mismatch");

	a_token_scan: assert property (@(posedge clk) disable iff (!arst_n)
		tok_c[ENTRIES].valid |-> state_q == S_SCAN)
		else $error("scan token outside scan");

	a_absent_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !rsp.present |-> rsp.count == '0)
		else $error("nonzero count for absent key");

endmodule

`default_nettype wire

[rtl/core/kct_cell.sv]
// ----------------------------------------------------------------------------
// kct_cell
// One table entry. Compares its key against the request key, folds its hit
// and free state into the scan token and passes the token to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module kct_cell import kct_pkg::*; #(
	parameter int IDX        = 0,
	parameter int IDX_W      = 5,
	parameter int KEY_USE    = KEY_BITS_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire  [KEY_USE-1:0]     key,
	input  cell_op_t               op,
	input  wire  [IDX_W-1:0]       ins_idx,
	input  wire  [COUNT_BITS-1:0]  wr_count,
	input  tok_t                   tok_in,
	input  wire  [COUNT_BITS-1:0]  cnt_in,
	input  wire  [IDX_W-1:0]       fidx_in,
	output tok_t                   tok_out,
	output logic [COUNT_BITS-1:0]  cnt_out,
	output logic [IDX_W-1:0]       fidx_out
);

	logic                  valid_q;
	logic [KEY_USE-1:0]    key_q;
	logic [COUNT_BITS-1:0] count_q;
	logic                  match;
	logic                  sel;

	assign match = valid_q && (key_q == key);
	assign sel   = op.ins && (ins_idx == IDX_W'(IDX));

	// entry storage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (sel) begin
			valid_q <= 1'b1;
		end else if (op.clr && match) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sel) begin
			key_q   <= key;
			count_q <= wr_count;
		end else if (op.upd && match) begin
			count_q <= wr_count;
		end
	end

	// scan token
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_out <= '0;
		end else begin
			tok_out.valid <= tok_in.valid;
			tok_out.hit   <= tok_in.hit || match;
			tok_out.free  <= tok_in.free || !valid_q;
		end
	end

	always_ff @(posedge clk) begin
		cnt_out  <= match ? count_q : cnt_in;
		fidx_out <= (!tok_in.free && !valid_q) ? IDX_W'(IDX) : fidx_in;
	end

endmodule

`default_nettype wire

[tb/tb_keyed_count_table_unit.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_keyed_count_table_unit
// Self-checking bench for the keyed count table. Requests go in through the
// start/busy handshake. A ledger class keeps its own copy of the table and
// works out each response as the request is accepted. Every done strobe is
// compared field by field with the oldest pending response. A short directed
// list comes first. Random phases follow that fill and then drain the table
// from a pool of keys, so hits, saturation, removal and a full table all
// occur. Random gaps fall between requests, outside phases 2 and 6.
// ----------------------------------------------------------------------------

module tb_keyed_count_table_unit;
	import kct_pkg::*;

	localparam int                 SLOTS      = ENTRIES_DEF;
	localparam logic [COUNT_W-1:0] CNT_MAX    = '1;
	localparam int                 POOL       = 40;
	localparam int                 PHASES     = 10;
	localparam int                 PHASE_LEN  = 175;
	localparam int                 TAIL_WAIT  = SLOTS + 8;

	class count_ledger;
		logic [KEY_W-1:0]   key_tab[SLOTS];
		logic [COUNT_W-1:0] cnt_tab[SLOTS];
		bit                 live[SLOTS];
		rsp_t               due[$];
		int                 errors;
		int                 checked;
		int                 status_seen[4];

		function int find_key(logic [KEY_W-1:0] k);
			for (int i = 0; i < SLOTS; i++)
				if (live[i] && key_tab[i] == k) return i;
			return -1;
		endfunction

		function int find_free();
			for (int i = 0; i < SLOTS; i++)
				if (!live[i]) return i;
			return -1;
		endfunction

		function logic [KEY_W-1:0] live_key();
			int idx[$];
			for (int i = 0; i < SLOTS; i++)
				if (live[i]) idx.push_back(i);
			if (idx.size() == 0) return '0;
			return key_tab[idx[$urandom_range(0, idx.size() - 1)]];
		endfunction

		function rsp_t predict(req_t r);
			logic [31:0]        raw;
			logic               pos;
			logic               keep;
			logic               want;
			logic [COUNT_W-1:0] val;
			logic [COUNT_W:0]   sum;
			int                 hit;
			int                 slot;
			status_t            st;
			rsp_t               o;
			raw  = r.amount;
			pos  = !raw[31] && raw != 0;
			keep = r.keep_zero;
			st   = ST_DONE;
			if (r.key == '0) begin
				o.status  = ST_INVALID;
				o.count   = '0;
				o.present = 1'b0;
				return o;
			end
			hit = find_key(r.key);
			case (r.command)
				CMD_ADD, CMD_SET: begin
					val  = pos ? raw[COUNT_W-1:0] : '0;
					want = (r.command == CMD_ADD) ? (pos || (raw == 0 && keep)) : (pos || keep);
					if (hit >= 0) begin
						if (r.command == CMD_ADD) begin
							if (pos) begin
								sum = {1'b0, cnt_tab[hit]} + {1'b0, val};
								cnt_tab[hit] = sum[COUNT_W] ? CNT_MAX : sum[COUNT_W-1:0];
							end else begin
								st = ST_NOEFFECT;
							end
						end else if (want) begin
							cnt_tab[hit] = val;
						end else begin
							live[hit] = 1'b0;
							hit = -1;
						end
					end else if (want) begin
						slot = find_free();
						if (slot < 0) begin
							st = ST_FULL;
						end else begin
							key_tab[slot] = r.key;
							cnt_tab[slot] = val;
							live[slot]    = 1'b1;
							hit = slot;
						end
					end else begin
						st = ST_NOEFFECT;
					end
				end
				CMD_REMOVE: begin
					if (!pos || hit < 0) begin
						st = ST_NOEFFECT;
					end else if ({1'b0, cnt_tab[hit]} <= raw) begin
						if (keep) begin
							cnt_tab[hit] = '0;
						end else begin
							live[hit] = 1'b0;
							hit = -1;
						end
					end else begin
						cnt_tab[hit] = cnt_tab[hit] - raw[COUNT_W-1:0];
					end
				end
				default: ;
			endcase
			o.status  = st;
			o.count   = (hit >= 0) ? cnt_tab[hit] : '0;
			o.present = (hit >= 0);
			return o;
		endfunction

		function void log_request(req_t r);
			due.push_back(predict(r));
		endfunction

		function void check_response(rsp_t a);
			rsp_t e;
			if (due.size() == 0) begin
				$display("%0t: unexpected response status=%0d count=%0d present=%0d",
					$time, a.status, a.count, a.present);
				errors++;
				return;
			end
			e = due.pop_front();
			checked++;
			status_seen[a.status]++;
			if (a.status !== e.status) begin
				$display("%0t: status mismatch expected=%0d actual=%0d", $time, e.status, a.status);
				errors++;
			end
			if (a.count !== e.count) begin
				$display("%0t: count mismatch expected=%0d actual=%0d", $time, e.count, a.count);
				errors++;
			end
			if (a.present !== e.present) begin
				$display("%0t: present mismatch expected=%0d actual=%0d",
					$time, e.present, a.present);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	req_t req;
	logic done;
	rsp_t rsp;

	count_ledger      ledger;
	logic [KEY_W-1:0] key_pool[POOL];
	int               sent;

	keyed_count_table_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.rsp    (rsp)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && done) ledger.check_response(rsp);
	end

	initial begin
		#2_000_000;
		$display("tb_keyed_count_table_unit: FAIL");
		$finish;
	end

	function automatic req_t mk(cmd_t c, logic [KEY_W-1:0] k, logic [31:0] a, logic kz);
		req_t r;
		r.command   = c;
		r.key       = k;
		r.amount    = a;
		r.keep_zero = kz;
		return r;
	endfunction

	function automatic logic [31:0] pick_amount();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40) return $urandom_range(1, 64);
		if (r < 50) return -$urandom_range(1, 64);
		if (r < 58) return 32'd0;
		if (r < 70) return $urandom;
		if (r < 78) return 32'h7fff_ffff;
		if (r < 83) return 32'h8000_0000;
		if (r < 90) return $urandom_range(32'h7fff_ff00, 32'h7fff_ffff);
		return $urandom_range(1, 1 << 20);
	endfunction

	function automatic req_t make_item(bit drain);
		req_t             r;
		int               kr;
		int               cr;
		logic [KEY_W-1:0] k;
		kr = $urandom_range(0, 99);
		cr = $urandom_range(0, 99);
		if (kr < 3) begin
			k = '0;
		end else if (kr < 8) begin
			k = KEY_W'($urandom);
		end else begin
			k = drain && kr < 70 ? ledger.live_key() : '0;
			if (k == '0) k = key_pool[$urandom_range(0, POOL - 1)];
		end
		if (!drain) begin
			r.command = cr < 50 ? CMD_ADD : cr < 70 ? CMD_SET : cr < 85 ? CMD_REMOVE : CMD_QUERY;
		end else begin
			r.command = cr < 15 ? CMD_ADD : cr < 40 ? CMD_SET : cr < 85 ? CMD_REMOVE : CMD_QUERY;
		end
		r.key       = k;
		r.amount    = pick_amount();
		r.keep_zero = 1'($urandom_range(0, 1));
		return r;
	endfunction

	function automatic int pick_gap(bit quiet);
		int r;
		if (quiet) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	task automatic issue(req_t r, int gap);
		start <= 1'b1;
		req   <= r;
		do @(posedge clk); while (busy);
		ledger.log_request(r);
		sent++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	initial begin
		req_t directed[$];
		ledger = new();
		sent   = 0;
		arst_n = 1'b0;
		start  = 1'b0;
		req    = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table, invalid key on every command, then the add/set/remove paths but a full table
		directed.push_back(mk(CMD_QUERY,  16'd1,    32'd0,          1'b0));
		directed.push_back(mk(CMD_ADD,    16'd0,    32'd5,          1'b1));
		directed.push_back(mk(CMD_SET,    16'd0,    32'd5,          1'b1));
		directed.push_back(mk(CMD_REMOVE, 16'd0,    32'd5,          1'b0));
		directed.push_back(mk(CMD_QUERY,  16'd0,    32'hffff_ffff,  1'b1));
		directed.push_back(mk(CMD_ADD,    16'd1,    32'd5,          1'b0));
		directed.push_back(mk(CMD_ADD,    16'd1,    32'h7fff_ffff,  1'b0));
		directed.push_back(mk(CMD_ADD,    16'd1,    32'hffff_fffd,  1'b0));
		directed.push_back(mk(CMD_ADD,    16'd1,    32'd0,          1'b1));
		directed.push_back(mk(CMD_ADD,    16'd2,    32'd0,          1'b0));
		directed.push_back(mk(CMD_ADD,    16'd2,    32'd0,          1'b1));
		directed.push_back(mk(CMD_SET,    16'd2,    32'hffff_fff9,  1'b1));
		directed.push_back(mk(CMD_SET,    16'd2,    32'h8000_0000,  1'b0));
		directed.push_back(mk(CMD_SET,    16'd3,    32'd0,          1'b0));
		directed.push_back(mk(CMD_SET,    16'hffff, 32'h7fff_ffff,  1'b0));
		directed.push_back(mk(CMD_SET,    16'hffff, 32'd100,        1'b0));
		directed.push_back(mk(CMD_REMOVE, 16'hffff, 32'd0,          1'b1));
		directed.push_back(mk(CMD_REMOVE, 16'hffff, 32'hffff_ffff,  1'b1));
		directed.push_back(mk(CMD_REMOVE, 16'd4,    32'd10,         1'b1));
		directed.push_back(mk(CMD_REMOVE, 16'hffff, 32'd40,         1'b0));
		directed.push_back(mk(CMD_REMOVE, 16'hffff, 32'd60,         1'b1));
		directed.push_back(mk(CMD_ADD,    16'hffff, 32'd9,          1'b0));
		directed.push_back(mk(CMD_REMOVE, 16'hffff, 32'h7fff_ffff,  1'b0));
		directed.push_back(mk(CMD_ADD,    16'haaaa, 32'h5555_5555,  1'b1));
		directed.push_back(mk(CMD_QUERY,  16'd1,    32'haaaa_aaaa,  1'b0));
		foreach (directed[i]) issue(directed[i], pick_gap(1'b0));

		// fill phases use a fresh key pool, drain phases mostly hit live keys
		for (int p = 0; p < PHASES; p++) begin
			if (p % 2 == 0)
				foreach (key_pool[i]) key_pool[i] = KEY_W'($urandom_range(1, 16'hffff));
			for (int n = 0; n < PHASE_LEN; n++)
				issue(make_item(p % 2 == 1), pick_gap(p % 4 == 2));
		end
		start <= 1'b0;

		while (ledger.due.size() != 0) @(posedge clk);
		repeat (TAIL_WAIT) @(posedge clk);

		$display("covered %0d requests, %0d responses checked", sent, ledger.checked);
		$display("status mix: done %0d, invalid %0d, no effect %0d, table full %0d",
			ledger.status_seen[ST_DONE], ledger.status_seen[ST_INVALID],
			ledger.status_seen[ST_NOEFFECT], ledger.status_seen[ST_FULL]);
		if (ledger.errors == 0) begin
			$display("tb_keyed_count_table_unit: PASS");
		end else begin
			$display("tb_keyed_count_table_unit: FAIL");
		end
		$finish;
	end

endmodule
